// ===== hw/rtl/bhac_pkg.sv =====
package bhac_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NORM_BITS = 30;

   // Parameters of every pipelined divider instance: quotient bits, divisor and dividend widths.
   localparam int DIV_Q_W   = NORM_BITS + 3;
   localparam int DIV_DEN_W = 65;
   localparam int DIV_NUM_W = 96;
   localparam int DIV_LAT   = DIV_Q_W;

   localparam logic [30:0] ONE_N   = 31'h4000_0000;
   localparam logic [30:0] HALF_N  = 31'h2000_0000;
   localparam logic [61:0] HALF_SQ = 62'h0800_0000_0000_0000;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_DEGEN = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef enum logic [1:0] {
      SOLVE_EMPTY,
      SOLVE_TRI,
      SOLVE_TRAP
   } solve_type;

   typedef struct packed {
      logic [1:0][31:0] mn;
      logic [1:0][31:0] e;
      logic [1:0]       flip;
      logic             sx;
      logic             degen;
   } geom_type;

   typedef struct packed {
      logic     vld;
      geom_type g;
      logic     ysat;
      logic     yneg;
   } d1_side_type;

   typedef struct packed {
      logic      vld;
      geom_type  g;
      logic      comp;
      solve_type cls;
      logic [30:0] volt;
   } d2_side_type;

   typedef struct packed {
      logic     vld;
      geom_type g;
      logic     comp;
      logic [30:0] vol;
      logic [30:0] cs;
      logic [30:0] cb;
      logic [30:0] rest;
   } d3_side_type;

endpackage

// ===== hw/rtl/bhac_div.sv =====
module bhac_div import bhac_pkg::*; (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic [DIV_Q_W-1:0]   quo
);

   // One quotient bit per stage. The dividend must be below den * 2^DIV_Q_W.
   logic [DIV_DEN_W-1:0] rem_ff  [DIV_Q_W];
   logic [DIV_Q_W-1:0]   low_ff  [DIV_Q_W];
   logic [DIV_DEN_W-1:0] den_ff  [DIV_Q_W];
   logic [DIV_Q_W-1:0]   quo_ff  [DIV_Q_W];

   logic [DIV_DEN_W-1:0] rem_src [DIV_Q_W];
   logic [DIV_Q_W-1:0]   low_src [DIV_Q_W];
   logic [DIV_DEN_W-1:0] den_src [DIV_Q_W];
   logic [DIV_Q_W-1:0]   quo_src [DIV_Q_W];

   logic [DIV_DEN_W-1:0] rem_in  [DIV_Q_W];
   logic [DIV_Q_W-1:0]   low_in  [DIV_Q_W];
   logic [DIV_Q_W-1:0]   quo_in  [DIV_Q_W];

   always_comb begin
      rem_src[0] = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
      low_src[0] = num[DIV_Q_W-1:0];
      den_src[0] = den;
      quo_src[0] = '0;
      for (int k = 1; k < DIV_Q_W; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
         den_src[k] = den_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
   end

   always_comb begin
      logic [DIV_DEN_W:0] trial;
      logic [DIV_DEN_W:0] diff;
      logic               ge;
      for (int k = 0; k < DIV_Q_W; k++) begin
         trial     = {rem_src[k], low_src[k][DIV_Q_W-1]};
         diff      = trial - {1'b0, den_src[k]};
         ge        = trial >= {1'b0, den_src[k]};
         rem_in[k] = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         low_in[k] = {low_src[k][DIV_Q_W-2:0], 1'b0};
         quo_in[k] = {quo_src[k][DIV_Q_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < DIV_Q_W; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_src[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[DIV_Q_W-1];

endmodule

// ===== hw/rtl/box_halfplane_area_centroid.sv =====
// Area and centroid of the part of an axis-aligned box that lies on the negative side of a
// half-plane, all in Q16.16 (area unsigned Q32.16). The block is a pipeline of 115
// register stages: a beat accepted on req_ passes through all of them to a valid rsp_
// beat, and one beat can be accepted in every cycle in which req_stall is low. Most of that
// depth is three rows of 33-stage dividers that retire one quotient bit per stage. A
// stalled rsp_ beat holds the whole pipeline; req_stall rises only while a finished beat
// waits and rsp_stall is high.
module box_halfplane_area_centroid import bhac_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_box_min_x,
   input  logic signed [31:0] req_box_min_y,
   input  logic signed [31:0] req_box_max_x,
   input  logic signed [31:0] req_box_max_y,
   input  logic signed [31:0] req_line_point_x,
   input  logic signed [31:0] req_line_point_y,
   input  logic signed [31:0] req_normal_x,
   input  logic signed [31:0] req_normal_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [47:0]        rsp_area,
   output logic signed [31:0] rsp_centroid_x,
   output logic signed [31:0] rsp_centroid_y,
   output logic [1:0]         rsp_status
);

   typedef struct packed {
      logic             vld;
      logic [1:0][31:0] bmin;
      logic [1:0][31:0] bmax;
      logic [1:0][31:0] pt;
      logic [1:0][31:0] nrm;
   } s1_type;

   typedef struct packed {
      logic             vld;
      geom_type         g;
      logic [1:0][31:0] an;
      logic [1:0][31:0] dm;
      logic [1:0]       tneg;
   } s2_type;

   typedef struct packed {
      logic             vld;
      geom_type         g;
      logic [1:0][63:0] nn;
      logic [1:0][63:0] tt;
      logic [1:0]       tneg;
   } s3_type;

   typedef struct packed {
      logic        vld;
      geom_type    g;
      logic [63:0] numx;
      logic [63:0] numy;
      logic [63:0] den;
      logic        yneg;
   } s4_type;

   typedef struct packed {
      logic        vld;
      geom_type    g;
      logic [30:0] x;
      logic [35:0] yv;
      logic        comp;
   } s6_type;

   typedef struct packed {
      logic        vld;
      geom_type    g;
      logic        comp;
      solve_type   cls;
      logic [30:0] ux;
      logic [30:0] uy;
      logic [30:0] v2;
      logic [31:0] t;
   } s7_type;

   typedef struct packed {
      logic        vld;
      geom_type    g;
      logic        comp;
      solve_type   cls;
      logic [30:0] ux;
      logic [30:0] uy;
      logic [30:0] v2;
      logic [31:0] t;
      logic [61:0] uy2;
      logic [61:0] ux2;
      logic [61:0] v2sq;
   } s8_type;

   typedef struct packed {
      logic        vld;
      geom_type    g;
      logic        comp;
      logic [30:0] vol;
      logic [30:0] cs;
      logic [30:0] cb;
   } s10_type;

   typedef struct packed {
      logic        vld;
      geom_type    g;
      logic        comp;
      logic [30:0] vol;
      logic [30:0] cs;
      logic [30:0] cb;
      logic [30:0] rest;
      logic [61:0] ms;
      logic [61:0] mb;
   } s11_type;

   typedef struct packed {
      logic        vld;
      geom_type    g;
      logic [1:0][30:0] c;
      logic [30:0] vol;
   } s13_type;

   typedef struct packed {
      logic             vld;
      geom_type         g;
      logic [1:0][63:0] off;
      logic [63:0]      pe;
      logic [30:0]      vol;
   } s14_type;

   typedef struct packed {
      logic             vld;
      logic             degen;
      logic [1:0][33:0] res;
      logic [62:0]      pl;
      logic [62:0]      ph;
   } s15_type;

   function automatic logic [63:0] s14_pe(input logic [31:0] a, input logic [31:0] b);
      s14_pe = a * b;
   endfunction

   logic adv;

   s1_type  s1_ff,  s1_in;
   s2_type  s2_ff,  s2_in;
   s3_type  s3_ff,  s3_in;
   s4_type  s4_ff,  s4_in;
   s6_type  s6_ff,  s6_in;
   s7_type  s7_ff,  s7_in;
   s8_type  s8_ff,  s8_in;
   s10_type s10_ff, s10_in;
   s11_type s11_ff, s11_in;
   s13_type s13_ff, s13_in;
   s14_type s14_ff, s14_in;
   s15_type s15_ff, s15_in;

   d1_side_type d1_side_ff, d1_side_in;
   d2_side_type d2_side_ff, d2_side_in;
   d3_side_type d3_side_ff, d3_side_in;
   d1_side_type d1_line_ff [DIV_LAT];
   d2_side_type d2_line_ff [DIV_LAT];
   d3_side_type d3_line_ff [DIV_LAT];

   logic [DIV_NUM_W-1:0] xnum_ff, xnum_in, ynum_ff, ynum_in;
   logic [DIV_DEN_W-1:0] xyden_ff, xyden_in;
   logic [DIV_NUM_W-1:0] vnum_ff, vnum_in, snum_ff, snum_in, bnum_ff, bnum_in;
   logic [DIV_DEN_W-1:0] vden_ff, vden_in, sden_ff, sden_in, bden_ff, bden_in;
   logic [DIV_NUM_W-1:0] csnum_ff, csnum_in, cbnum_ff, cbnum_in;
   logic [DIV_DEN_W-1:0] cden_ff, cden_in;
   logic [DIV_Q_W-1:0]   qx, qy, qv, qs, qb, qcs, qcb;

   logic        rsp_valid_ff;
   logic [47:0] rsp_area_ff, rsp_area_in;
   logic [31:0] rsp_cx_ff, rsp_cx_in, rsp_cy_ff, rsp_cy_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Input register.
   always_comb begin
      s1_in.vld     = req_valid;
      s1_in.bmin[0] = req_box_min_x;
      s1_in.bmin[1] = req_box_min_y;
      s1_in.bmax[0] = req_box_max_x;
      s1_in.bmax[1] = req_box_max_y;
      s1_in.pt[0]   = req_line_point_x;
      s1_in.pt[1]   = req_line_point_y;
      s1_in.nrm[0]  = req_normal_x;
      s1_in.nrm[1]  = req_normal_y;
   end

   // Edges, normal magnitudes and the signed offsets of the line from the near corner.
   always_comb begin
      logic [32:0] ediff;
      logic [31:0] e;
      logic [33:0] hi;
      logic [33:0] d;
      s2_in     = '0;
      s2_in.vld = s1_ff.vld;
      for (int i = 0; i < 2; i++) begin
         ediff = 33'($signed(s1_ff.bmax[i])) - 33'($signed(s1_ff.bmin[i]));
         e = ediff[32] ? 32'd0 : ediff[31:0];
         hi = 34'($signed(s1_ff.bmin[i])) + 34'(e);
         if (s1_ff.nrm[i][31]) begin
            d = hi - 34'($signed(s1_ff.pt[i]));
         end else begin
            d = 34'($signed(s1_ff.pt[i])) - 34'($signed(s1_ff.bmin[i]));
         end
         s2_in.g.mn[i]   = s1_ff.bmin[i];
         s2_in.g.e[i]    = e;
         s2_in.g.flip[i] = s1_ff.nrm[i][31];
         s2_in.an[i]     = s1_ff.nrm[i][31] ? 32'd0 - s1_ff.nrm[i] : s1_ff.nrm[i];
         s2_in.tneg[i]   = d[33];
         s2_in.dm[i]     = d[33] ? 32'(34'd0 - d) : d[31:0];
      end
   end

   always_comb begin
      s3_in.vld  = s2_ff.vld;
      s3_in.g    = s2_ff.g;
      s3_in.tneg = s2_ff.tneg;
      for (int i = 0; i < 2; i++) begin
         s3_in.nn[i] = s2_ff.an[i] * s2_ff.g.e[i];
         s3_in.tt[i] = s2_ff.an[i] * s2_ff.dm[i];
      end
   end

   // Axis exchange and the combined line offset.
   always_comb begin
      logic sx;
      sx = !(s3_ff.nn[1] >= s3_ff.nn[0]);
      s4_in.vld   = s3_ff.vld;
      s4_in.g     = s3_ff.g;
      s4_in.g.sx  = sx;
      s4_in.numx  = sx ? s3_ff.nn[1] : s3_ff.nn[0];
      s4_in.den   = sx ? s3_ff.nn[0] : s3_ff.nn[1];
      s4_in.g.degen = (sx ? s3_ff.nn[0] : s3_ff.nn[1]) == 64'd0;
      if (s3_ff.tneg[0] == s3_ff.tneg[1]) begin
         s4_in.numy = s3_ff.tt[0] + s3_ff.tt[1];
         s4_in.yneg = s3_ff.tneg[0];
      end else if (s3_ff.tt[0] >= s3_ff.tt[1]) begin
         s4_in.numy = s3_ff.tt[0] - s3_ff.tt[1];
         s4_in.yneg = s3_ff.tneg[0];
      end else begin
         s4_in.numy = s3_ff.tt[1] - s3_ff.tt[0];
         s4_in.yneg = s3_ff.tneg[1];
      end
   end

   // Rounded ratios are floor((n * 2^31 + den) / (2 * den)); a ratio of 4.0 or more clamps.
   always_comb begin
      logic [63:0] den_e;
      logic        ysat;
      den_e = s4_ff.g.degen ? 64'd1 : s4_ff.den;
      ysat  = {2'b00, s4_ff.numy} >= {den_e, 2'b00};
      xnum_in  = DIV_NUM_W'({s4_ff.numx, 31'd0}) + DIV_NUM_W'(den_e);
      ynum_in  = ysat ? DIV_NUM_W'(den_e)
                      : DIV_NUM_W'({s4_ff.numy, 31'd0}) + DIV_NUM_W'(den_e);
      xyden_in = {den_e, 1'b0};
      d1_side_in.vld  = s4_ff.vld;
      d1_side_in.g    = s4_ff.g;
      d1_side_in.ysat = ysat;
      d1_side_in.yneg = s4_ff.yneg;
   end

   bhac_div u_div_x (.clock(clock), .enable(adv), .num(xnum_ff), .den(xyden_ff), .quo(qx));
   bhac_div u_div_y (.clock(clock), .enable(adv), .num(ynum_ff), .den(xyden_ff), .quo(qy));

   // Complement when more than half of the unit square is covered.
   always_comb begin
      logic [32:0] ymag;
      logic [35:0] ys;
      logic [35:0] xb;
      logic [35:0] dbl;
      logic [35:0] yc;
      logic        comp;
      ymag = d1_line_ff[DIV_LAT-1].ysat ? 33'h1_0000_0000 : qy;
      ys   = d1_line_ff[DIV_LAT-1].yneg ? 36'd0 - 36'(ymag) : 36'(ymag);
      xb   = 36'(qx[30:0]);
      dbl  = {ys[34:0], 1'b0} - xb;
      yc   = 36'(ONE_N) - ys + xb;
      comp = $signed(dbl) > $signed(36'(ONE_N));
      s6_in.vld  = d1_line_ff[DIV_LAT-1].vld;
      s6_in.g    = d1_line_ff[DIV_LAT-1].g;
      s6_in.x    = qx[30:0];
      s6_in.yv   = comp ? yc : ys;
      s6_in.comp = comp;
   end

   // Case split: empty, triangle or trapezoid.
   always_comb begin
      logic [32:0] v2w;
      logic [33:0] tw;
      logic [30:0] uy;
      uy  = s6_ff.yv[30:0];
      v2w = 33'({uy, 1'b0}) - 33'(s6_ff.x);
      tw  = 34'(uy) + 34'({uy, 1'b0}) - 34'({s6_ff.x, 1'b0});
      s7_in.vld  = s6_ff.vld;
      s7_in.g    = s6_ff.g;
      s7_in.comp = s6_ff.comp;
      if (s6_ff.yv[35] || s6_ff.yv == 36'd0) begin
         s7_in.cls = SOLVE_EMPTY;
      end else if (s6_ff.yv <= 36'(s6_ff.x)) begin
         s7_in.cls = SOLVE_TRI;
      end else begin
         s7_in.cls = SOLVE_TRAP;
      end
      s7_in.ux = s6_ff.x;
      s7_in.uy = uy;
      s7_in.v2 = v2w[30:0];
      s7_in.t  = tw[31:0];
   end

   always_comb begin
      s8_in.vld  = s7_ff.vld;
      s8_in.g    = s7_ff.g;
      s8_in.comp = s7_ff.comp;
      s8_in.cls  = s7_ff.cls;
      s8_in.ux   = s7_ff.ux;
      s8_in.uy   = s7_ff.uy;
      s8_in.v2   = s7_ff.v2;
      s8_in.t    = s7_ff.t;
      s8_in.uy2  = s7_ff.uy * s7_ff.uy;
      s8_in.ux2  = s7_ff.ux * s7_ff.ux;
      s8_in.v2sq = s7_ff.v2 * s7_ff.v2;
   end

   // Dividends carry half the divisor so that the floor division rounds half up.
   always_comb begin
      logic [32:0] ux3;
      logic [32:0] v23;
      logic [31:0] v2p;
      ux3 = 33'(s8_ff.ux) + 33'({s8_ff.ux, 1'b0});
      v23 = 33'(s8_ff.v2) + 33'({s8_ff.v2, 1'b0});
      v2p = 32'(s8_ff.v2) + 32'd1;
      vnum_in = DIV_NUM_W'(s8_ff.uy2) + DIV_NUM_W'(s8_ff.ux);
      vden_in = DIV_DEN_W'({s8_ff.ux, 1'b0});
      if (s8_ff.cls == SOLVE_TRAP) begin
         snum_in = DIV_NUM_W'({s8_ff.t, 30'd0}) + DIV_NUM_W'(v23[32:1]);
         sden_in = DIV_DEN_W'(v23);
         bnum_in = DIV_NUM_W'(s8_ff.v2sq) + DIV_NUM_W'({s8_ff.v2sq, 1'b0})
                 + DIV_NUM_W'(s8_ff.ux2) + DIV_NUM_W'({s8_ff.v2, 2'b00})
                 + DIV_NUM_W'({s8_ff.v2, 1'b0});
         bden_in = DIV_DEN_W'({s8_ff.v2, 3'b000}) + DIV_DEN_W'({s8_ff.v2, 2'b00});
      end else begin
         snum_in = DIV_NUM_W'({s8_ff.uy, 30'd0}) + DIV_NUM_W'(ux3[32:1]);
         sden_in = DIV_DEN_W'(ux3);
         bnum_in = DIV_NUM_W'(s8_ff.uy) + DIV_NUM_W'(1);
         bden_in = DIV_DEN_W'(3);
      end
      d2_side_in.vld  = s8_ff.vld;
      d2_side_in.g    = s8_ff.g;
      d2_side_in.comp = s8_ff.comp;
      d2_side_in.cls  = s8_ff.cls;
      d2_side_in.volt = v2p[31:1];
   end

   bhac_div u_div_v (.clock(clock), .enable(adv), .num(vnum_ff), .den(vden_ff), .quo(qv));
   bhac_div u_div_s (.clock(clock), .enable(adv), .num(snum_ff), .den(sden_ff), .quo(qs));
   bhac_div u_div_b (.clock(clock), .enable(adv), .num(bnum_ff), .den(bden_ff), .quo(qb));

   always_comb begin
      s10_in.vld = d2_line_ff[DIV_LAT-1].vld;
      s10_in.g   = d2_line_ff[DIV_LAT-1].g;
      case (d2_line_ff[DIV_LAT-1].cls)
         SOLVE_TRI: begin
            s10_in.vol  = qv[30:0];
            s10_in.cs   = qs[30:0];
            s10_in.cb   = qb[30:0];
            s10_in.comp = d2_line_ff[DIV_LAT-1].comp;
         end
         SOLVE_TRAP: begin
            s10_in.vol  = d2_line_ff[DIV_LAT-1].volt;
            s10_in.cs   = qs[30:0];
            s10_in.cb   = qb[30:0];
            s10_in.comp = d2_line_ff[DIV_LAT-1].comp;
         end
         default: begin
            s10_in.vol  = d2_line_ff[DIV_LAT-1].comp ? ONE_N : 31'd0;
            s10_in.cs   = HALF_N;
            s10_in.cb   = HALF_N;
            s10_in.comp = 1'b0;
         end
      endcase
   end

   always_comb begin
      s11_in.vld  = s10_ff.vld;
      s11_in.g    = s10_ff.g;
      s11_in.comp = s10_ff.comp;
      s11_in.vol  = s10_ff.vol;
      s11_in.cs   = s10_ff.cs;
      s11_in.cb   = s10_ff.cb;
      s11_in.rest = ONE_N - s10_ff.vol;
      s11_in.ms   = s10_ff.vol * s10_ff.cs;
      s11_in.mb   = s10_ff.vol * s10_ff.cb;
   end

   // Centroid of the complement from the moment of the whole square.
   always_comb begin
      logic [61:0] ds;
      logic [61:0] db;
      ds = (HALF_SQ > s11_ff.ms) ? HALF_SQ - s11_ff.ms : 62'd0;
      db = (HALF_SQ > s11_ff.mb) ? HALF_SQ - s11_ff.mb : 62'd0;
      csnum_in = DIV_NUM_W'(ds) + DIV_NUM_W'(s11_ff.rest[30:1]);
      cbnum_in = DIV_NUM_W'(db) + DIV_NUM_W'(s11_ff.rest[30:1]);
      cden_in  = DIV_DEN_W'(s11_ff.rest);
      d3_side_in.vld  = s11_ff.vld;
      d3_side_in.g    = s11_ff.g;
      d3_side_in.comp = s11_ff.comp;
      d3_side_in.vol  = s11_ff.vol;
      d3_side_in.cs   = s11_ff.cs;
      d3_side_in.cb   = s11_ff.cb;
      d3_side_in.rest = s11_ff.rest;
   end

   bhac_div u_div_cs (.clock(clock), .enable(adv), .num(csnum_ff), .den(cden_ff), .quo(qcs));
   bhac_div u_div_cb (.clock(clock), .enable(adv), .num(cbnum_ff), .den(cden_ff), .quo(qcb));

   // Undo the complement, the axis exchange and the flips; a degenerate box gets zero area.
   always_comb begin
      d3_side_type sd;
      logic [30:0] cs;
      logic [30:0] cb;
      logic [30:0] vol;
      logic [30:0] c0;
      logic [30:0] c1;
      sd  = d3_line_ff[DIV_LAT-1];
      cs  = sd.cs;
      cb  = sd.cb;
      vol = sd.vol;
      if (sd.comp) begin
         cs  = ONE_N - ((qcs > DIV_Q_W'(ONE_N)) ? ONE_N : qcs[30:0]);
         cb  = ONE_N - ((qcb > DIV_Q_W'(ONE_N)) ? ONE_N : qcb[30:0]);
         vol = sd.rest;
      end
      if (sd.g.degen) begin
         cs  = HALF_N;
         cb  = HALF_N;
         vol = 31'd0;
      end
      c0 = sd.g.sx ? cb : cs;
      c1 = sd.g.sx ? cs : cb;
      s13_in.vld  = sd.vld;
      s13_in.g    = sd.g;
      s13_in.c[0] = sd.g.flip[0] ? ONE_N - c0 : c0;
      s13_in.c[1] = sd.g.flip[1] ? ONE_N - c1 : c1;
      s13_in.vol  = vol;
   end

   always_comb begin
      s14_in.vld = s13_ff.vld;
      s14_in.g   = s13_ff.g;
      s14_in.vol = s13_ff.vol;
      for (int i = 0; i < 2; i++) begin
         s14_in.off[i] = s13_ff.c[i] * s13_ff.g.e[i];
      end
      s14_in.pe = s14_pe(s13_ff.g.e[0], s13_ff.g.e[1]);
   end

   always_comb begin
      logic [63:0] rnd;
      s15_in.vld   = s14_ff.vld;
      s15_in.degen = s14_ff.g.degen;
      for (int i = 0; i < 2; i++) begin
         rnd = s14_ff.off[i] + 64'(HALF_N);
         s15_in.res[i] = 34'($signed(s14_ff.g.mn[i])) + 34'(rnd[62:NORM_BITS]);
      end
      s15_in.pl = s14_ff.pe[31:0] * s14_ff.vol;
      s15_in.ph = s14_ff.pe[63:32] * s14_ff.vol;
   end

   // Area rounding and saturation of every field.
   always_comb begin
      logic [95:0] a;
      logic [49:0] ash;
      logic        sat;
      logic [31:0] cr [2];
      a   = 96'(s15_ff.pl) + {1'b0, s15_ff.ph, 32'd0}
          + (96'd1 << (NORM_BITS + FRAC_BITS - 1));
      ash = a[95:NORM_BITS+FRAC_BITS];
      sat = ash[49:48] != 2'b00;
      rsp_area_in = sat ? 48'hFFFF_FFFF_FFFF : ash[47:0];
      for (int i = 0; i < 2; i++) begin
         if (!s15_ff.res[i][33] && s15_ff.res[i][32:31] != 2'b00) begin
            cr[i] = 32'h7FFF_FFFF;
            sat   = 1'b1;
         end else if (s15_ff.res[i][33] && s15_ff.res[i][32:31] != 2'b11) begin
            cr[i] = 32'h8000_0000;
            sat   = 1'b1;
         end else begin
            cr[i] = s15_ff.res[i][31:0];
         end
      end
      rsp_cx_in = cr[0];
      rsp_cy_in = cr[1];
      if (s15_ff.degen) begin
         rsp_status_in = STATUS_DEGEN;
      end else if (sat) begin
         rsp_status_in = STATUS_SAT;
      end else begin
         rsp_status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld      <= 1'b0;
         s2_ff.vld      <= 1'b0;
         s3_ff.vld      <= 1'b0;
         s4_ff.vld      <= 1'b0;
         d1_side_ff.vld <= 1'b0;
         s6_ff.vld      <= 1'b0;
         s7_ff.vld      <= 1'b0;
         s8_ff.vld      <= 1'b0;
         d2_side_ff.vld <= 1'b0;
         s10_ff.vld     <= 1'b0;
         s11_ff.vld     <= 1'b0;
         d3_side_ff.vld <= 1'b0;
         s13_ff.vld     <= 1'b0;
         s14_ff.vld     <= 1'b0;
         s15_ff.vld     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            d1_line_ff[k].vld <= 1'b0;
            d2_line_ff[k].vld <= 1'b0;
            d3_line_ff[k].vld <= 1'b0;
         end
      end else if (adv) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_ff      <= s4_in;
         d1_side_ff <= d1_side_in;
         s6_ff      <= s6_in;
         s7_ff      <= s7_in;
         s8_ff      <= s8_in;
         d2_side_ff <= d2_side_in;
         s10_ff     <= s10_in;
         s11_ff     <= s11_in;
         d3_side_ff <= d3_side_in;
         s13_ff     <= s13_in;
         s14_ff     <= s14_in;
         s15_ff     <= s15_in;
         rsp_valid_ff <= s15_ff.vld;
         d1_line_ff[0] <= d1_side_ff;
         d2_line_ff[0] <= d2_side_ff;
         d3_line_ff[0] <= d3_side_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            d1_line_ff[k] <= d1_line_ff[k-1];
            d2_line_ff[k] <= d2_line_ff[k-1];
            d3_line_ff[k] <= d3_line_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xnum_ff       <= xnum_in;
         ynum_ff       <= ynum_in;
         xyden_ff      <= xyden_in;
         vnum_ff       <= vnum_in;
         vden_ff       <= vden_in;
         snum_ff       <= snum_in;
         sden_ff       <= sden_in;
         bnum_ff       <= bnum_in;
         bden_ff       <= bden_in;
         csnum_ff      <= csnum_in;
         cbnum_ff      <= cbnum_in;
         cden_ff       <= cden_in;
         rsp_area_ff   <= rsp_area_in;
         rsp_cx_ff     <= rsp_cx_in;
         rsp_cy_ff     <= rsp_cy_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_area       = rsp_area_ff;
   assign rsp_centroid_x = rsp_cx_ff;
   assign rsp_centroid_y = rsp_cy_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
